>>> sv/bmhq_pkg.sv
// Package for the binary min-heap queue: field widths, codes, controller
// states and the command and status words between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 11;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UP_CHECK,
        ST_UP_CMP,
        ST_POP_LAST,
        ST_POP_KEY,
        ST_DN_CHECK,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_LAST_WR,
        ST_RESULT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_SET_FULL,
        DP_SET_EMPTY,
        DP_PUSH_INIT,
        DP_RD_PARENT,
        DP_UP_MOVE,
        DP_WR_KEY,
        DP_RD_ROOT,
        DP_RD_LAST,
        DP_LOAD_KEY,
        DP_RD_LEFT,
        DP_MOVE_LEFT,
        DP_RD_RIGHT,
        DP_MOVE_CHOSEN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic op_is_deq;
        logic full;
        logic empty;
        logic at_root;
        logic no_child;
        logic one_child;
        logic key_lt_rd;
        logic rd_lt_key;
        logic chosen_lt_key;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> sv/bmhq_if.sv
// Handshake interfaces for the request and response words of the heap queue.
// Depends on bmhq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_in_if import bmhq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [0:0]              opcode;
    logic signed [KEY_W-1:0] key_in;

    modport source (output valid, output opcode, output key_in, input ready);
    modport sink   (input valid, input opcode, input key_in, output ready);
endinterface

interface bmhq_out_if import bmhq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key_out;
    logic [STATUS_W-1:0]     status;
    logic [ENTRY_W-1:0]      entry_count;

    modport source (output valid, output key_out, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input key_out, input status, input entry_count,
                    output ready);
endinterface

`default_nettype wire

>>> sv/bmhq_ctrl.sv
// Sequencer of the heap queue: walks each operation through the sift steps
// and issues one datapath command per cycle. Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = DP_NOP;
        o_cmd.load_out = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_CAPTURE;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_stat.op_is_deq) begin
                    if (i_stat.full) begin
                        o_cmd.op = DP_SET_FULL;
                        n_state  = ST_RESULT;
                    end else begin
                        o_cmd.op = DP_PUSH_INIT;
                        n_state  = ST_UP_CHECK;
                    end
                end else if (i_stat.empty) begin
                    o_cmd.op = DP_SET_EMPTY;
                    n_state  = ST_RESULT;
                end else begin
                    o_cmd.op = DP_RD_ROOT;
                    n_state  = ST_POP_LAST;
                end
            end
            ST_UP_CHECK: begin
                if (i_stat.at_root) begin
                    o_cmd.op = DP_WR_KEY;
                    n_state  = ST_RESULT;
                end else begin
                    o_cmd.op = DP_RD_PARENT;
                    n_state  = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (i_stat.key_lt_rd) begin
                    o_cmd.op = DP_UP_MOVE;
                    n_state  = ST_UP_CHECK;
                end else begin
                    o_cmd.op = DP_WR_KEY;
                    n_state  = ST_RESULT;
                end
            end
            ST_POP_LAST: begin
                o_cmd.op = DP_RD_LAST;
                n_state  = ST_POP_KEY;
            end
            ST_POP_KEY: begin
                o_cmd.op = DP_LOAD_KEY;
                n_state  = ST_DN_CHECK;
            end
            ST_DN_CHECK: begin
                if (i_stat.no_child) begin
                    o_cmd.op = DP_WR_KEY;
                    n_state  = ST_RESULT;
                end else begin
                    o_cmd.op = DP_RD_LEFT;
                    n_state  = ST_DN_LEFT;
                end
            end
            ST_DN_LEFT: begin
                // With a left child only, the entry sinks at most once more.
                if (!i_stat.one_child) begin
                    o_cmd.op = DP_RD_RIGHT;
                    n_state  = ST_DN_RIGHT;
                end else if (i_stat.rd_lt_key) begin
                    o_cmd.op = DP_MOVE_LEFT;
                    n_state  = ST_DN_LAST_WR;
                end else begin
                    o_cmd.op = DP_WR_KEY;
                    n_state  = ST_RESULT;
                end
            end
            ST_DN_RIGHT: begin
                if (i_stat.chosen_lt_key) begin
                    o_cmd.op = DP_MOVE_CHOSEN;
                    n_state  = ST_DN_CHECK;
                end else begin
                    o_cmd.op = DP_WR_KEY;
                    n_state  = ST_RESULT;
                end
            end
            ST_DN_LAST_WR: begin
                o_cmd.op = DP_WR_KEY;
                n_state  = ST_RESULT;
            end
            ST_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/bmhq_datapath.sv
// Datapath of the heap queue: heap memory, fill count, sift position, the
// sinking or rising key, comparators and the output register. Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_datapath import bmhq_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_stat                     o_stat,
    input  wire logic [0:0]              i_opcode,
    input  wire logic signed [KEY_W-1:0] i_key_in,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic signed [KEY_W-1:0]      o_key_out,
    output logic [STATUS_W-1:0]          o_status,
    output logic [ENTRY_W-1:0]           o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic signed [KEY_W-1:0] r_mem [CAPACITY];
    logic signed [KEY_W-1:0] r_rd_data;

    t_opcode                 r_op,      n_op;
    logic [CW-1:0]           r_count,   n_count;
    logic [CW-1:0]           r_pos,     n_pos;
    logic signed [KEY_W-1:0] r_key,     n_key;
    logic signed [KEY_W-1:0] r_child,   n_child;
    logic signed [KEY_W-1:0] r_key_out, n_key_out;
    t_status                 r_res,     n_res;

    logic                    r_out_valid;
    logic signed [KEY_W-1:0] r_out_key;
    t_status                 r_out_status;
    logic [ENTRY_W-1:0]      r_out_count;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;

    logic [CW:0]             left_pos;
    logic [CW:0]             left_addr;
    logic [CW:0]             count_ext;
    logic [CW-1:0]           pos_addr;
    logic [CW-1:0]           parent_addr;
    logic [CW-1:0]           last_addr;
    logic                    left_lt_right;
    logic signed [KEY_W-1:0] chosen_key;
    logic [CW:0]             chosen_pos;

    // Slot k of the heap lives at address k-1; children of slot p are 2p and 2p+1.
    assign left_pos      = {r_pos, 1'b0};
    assign left_addr     = left_pos - 1'b1;
    assign count_ext     = {1'b0, r_count};
    assign pos_addr      = r_pos - 1'b1;
    assign parent_addr   = (r_pos >> 1) - 1'b1;
    assign last_addr     = r_count - 1'b1;
    // On a tie between the children the right one is taken.
    assign left_lt_right = r_child < r_rd_data;
    assign chosen_key    = left_lt_right ? r_child : r_rd_data;
    assign chosen_pos    = left_lt_right ? left_pos : left_pos + 1'b1;

    always_comb begin
        o_stat.op_is_deq     = (r_op == OP_DEQ);
        o_stat.full          = (r_count == CW'(CAPACITY));
        o_stat.empty         = (r_count == '0);
        o_stat.at_root       = (r_pos == CW'(1));
        o_stat.no_child      = (count_ext < left_pos);
        o_stat.one_child     = (count_ext == left_pos);
        o_stat.key_lt_rd     = (r_key < r_rd_data);
        o_stat.rd_lt_key     = (r_rd_data < r_key);
        o_stat.chosen_lt_key = (chosen_key < r_key);
        o_stat.out_busy      = r_out_valid && !i_out_ready;
    end

    always_comb begin
        n_op      = r_op;
        n_count   = r_count;
        n_pos     = r_pos;
        n_key     = r_key;
        n_child   = r_child;
        n_key_out = r_key_out;
        n_res     = r_res;
        wr_en     = 1'b0;
        wr_addr   = pos_addr[AW-1:0];
        wr_data   = r_key;
        rd_en     = 1'b0;
        rd_addr   = '0;
        case (i_cmd.op)
            DP_NOP: begin
            end
            DP_CAPTURE: begin
                n_op  = t_opcode'(i_opcode);
                n_key = i_key_in;
            end
            DP_SET_FULL: begin
                n_res     = STATUS_FULL;
                n_key_out = '0;
            end
            DP_SET_EMPTY: begin
                n_res     = STATUS_EMPTY;
                n_key_out = '0;
            end
            DP_PUSH_INIT: begin
                n_res     = STATUS_OK;
                n_key_out = '0;
                n_count   = r_count + 1'b1;
                n_pos     = r_count + 1'b1;
            end
            DP_RD_PARENT: begin
                rd_en   = 1'b1;
                rd_addr = parent_addr[AW-1:0];
            end
            DP_UP_MOVE: begin
                wr_en   = 1'b1;
                wr_data = r_rd_data;
                n_pos   = r_pos >> 1;
            end
            DP_WR_KEY: begin
                wr_en = 1'b1;
            end
            DP_RD_ROOT: begin
                n_res   = STATUS_OK;
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            DP_RD_LAST: begin
                n_key_out = r_rd_data;
                rd_en     = 1'b1;
                rd_addr   = last_addr[AW-1:0];
                n_count   = r_count - 1'b1;
                n_pos     = CW'(1);
            end
            DP_LOAD_KEY: begin
                n_key = r_rd_data;
            end
            DP_RD_LEFT: begin
                rd_en   = 1'b1;
                rd_addr = left_addr[AW-1:0];
            end
            DP_MOVE_LEFT: begin
                wr_en   = 1'b1;
                wr_data = r_rd_data;
                n_pos   = left_pos[CW-1:0];
            end
            DP_RD_RIGHT: begin
                n_child = r_rd_data;
                rd_en   = 1'b1;
                rd_addr = left_pos[AW-1:0];
            end
            DP_MOVE_CHOSEN: begin
                wr_en   = 1'b1;
                wr_data = chosen_key;
                n_pos   = chosen_pos[CW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_child   <= n_child;
        r_key_out <= n_key_out;
        r_res     <= n_res;
        if (i_cmd.load_out) begin
            r_out_key    <= r_key_out;
            r_out_status <= r_res;
            r_out_count  <= ENTRY_W'(r_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_out     = r_out_key;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

>>> sv/binary_min_heap_queue.sv
// Binary min-heap priority queue, one request word in and one response word out.
// One word is worked at a time; the heap memory has a single read and write port, and the
// request side is ready again in the cycle after the response is loaded.
// Reset clears the fill count and the control; the heap memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int CAPACITY = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bmhq_in_if.sink    i_req,
    bmhq_out_if.source o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bmhq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bmhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_req.opcode),
        .i_key_in      (i_req.key_in),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_key_out     (o_rsp.key_out),
        .o_status      (o_rsp.status),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for binary_min_heap_queue: a scoreboard class keeps its own heap
// and predicts every response word, while plain tasks drive the request side and an initial block the response side.
// Depends on bmhq_pkg, the bmhq_in_if / bmhq_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module testbench;
    import bmhq_pkg::*;

    localparam int HEAP_CAP   = 1024;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 250;
    localparam int IDLE_PCT   = 23;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        t_status                 status;
        logic [ENTRY_W-1:0]      count;
    } t_heap_reply;

    class heap_scoreboard;
        logic signed [KEY_W-1:0] heap_mem [HEAP_CAP];
        int unsigned             held;
        t_heap_reply             due_replies [$];
        int unsigned             mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [KEY_W-1:0] tmp;
            tmp            = heap_mem[a-1];
            heap_mem[a-1]  = heap_mem[b-1];
            heap_mem[b-1]  = tmp;
        endfunction

        function void heap_insert(logic signed [KEY_W-1:0] key);
            int unsigned slot;
            held++;
            slot = held;
            heap_mem[slot-1] = key;
            while (slot > 1 && heap_mem[slot-1] < heap_mem[slot/2-1]) begin
                swap_slots(slot, slot/2);
                slot = slot / 2;
            end
        endfunction

        // The last key goes to the root and sinks toward the smaller child, the right one
        // on a tie, stopping as soon as that child is not strictly smaller.
        function logic signed [KEY_W-1:0] heap_extract_min();
            logic signed [KEY_W-1:0] root;
            int unsigned             parent;
            int unsigned             left;
            int unsigned             pick;
            bit                      done;
            root        = heap_mem[0];
            heap_mem[0] = heap_mem[held-1];
            held--;
            parent = 1;
            done   = 1'b0;
            while (!done) begin
                left = 2 * parent;
                if (held < left) begin
                    done = 1'b1;
                end else if (held == left) begin
                    if (heap_mem[left-1] < heap_mem[parent-1])
                        swap_slots(left, parent);
                    done = 1'b1;
                end else begin
                    pick = (heap_mem[left-1] < heap_mem[left]) ? left : left + 1;
                    if (heap_mem[pick-1] < heap_mem[parent-1]) begin
                        swap_slots(pick, parent);
                        parent = pick;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            return root;
        endfunction

        function void record_request(t_opcode op, logic signed [KEY_W-1:0] key);
            t_heap_reply r;
            r.key    = '0;
            r.status = STATUS_OK;
            if (op == OP_ENQ) begin
                if (held >= HEAP_CAP)
                    r.status = STATUS_FULL;
                else
                    heap_insert(key);
            end else if (held == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.key = heap_extract_min();
            end
            r.count = ENTRY_W'(held);
            due_replies.push_back(r);
        endfunction

        function void check_response(logic signed [KEY_W-1:0] key,
                                     logic [STATUS_W-1:0] status,
                                     logic [ENTRY_W-1:0] count);
            t_heap_reply want;
            if (due_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response word with none pending: key %0d status %0d count %0d",
                             key, status, count);
                return;
            end
            want = due_replies.pop_front();
            if (want.key !== key || want.status !== status || want.count !== count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: key exp %0d got %0d, status exp %0d got %0d, count exp %0d got %0d",
                             want.key, key, want.status, status, want.count, count);
            end
        endfunction

        function int unsigned pending();
            return due_replies.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmhq_in_if  req_if ();
    bmhq_out_if rsp_if ();

    binary_min_heap_queue #(.CAPACITY(HEAP_CAP)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    heap_scoreboard sb = new();
    int unsigned    words_sent = 0;
    int unsigned    replies_taken = 0;
    int unsigned    cycle_count = 0;
    bit             steady_run = 1'b0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("FAIL binary_min_heap_queue");
            $finish;
        end
    end

    // Extremes and a narrow band of values turn up often so that equal keys meet in the heap.
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2, 3:    return $signed(KEY_W'($urandom_range(15))) - 8;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_word(input t_opcode op, input logic signed [KEY_W-1:0] key);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.key_in <= key;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        sb.record_request(op, key);
        words_sent++;
        steady_run = (words_sent >= 400 && words_sent < 600);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // The response side stalls at random outside the steady run, apart from one long hold-off that lets the
    // block fill up and stop taking request words.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                sb.check_response(rsp_if.key_out, rsp_if.status, rsp_if.entry_count);
                replies_taken++;
                if (replies_taken == HOLD_AT)
                    hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.opcode <= OP_ENQ;
        req_if.key_in <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, extreme keys, equal keys, then drain past empty.
        send_word(OP_DEQ, 32'sh5A5A_5A5A);
        send_word(OP_ENQ, KEY_MAX);
        send_word(OP_ENQ, KEY_MIN);
        send_word(OP_ENQ, 32'sd0);
        send_word(OP_ENQ, -32'sd1);
        send_word(OP_ENQ, 32'sd7);
        send_word(OP_ENQ, 32'sd7);
        send_word(OP_ENQ, 32'sd7);
        send_word(OP_ENQ, 32'sd3);
        send_word(OP_ENQ, 32'sd3);
        send_word(OP_ENQ, KEY_MIN);
        send_word(OP_DEQ, -32'sd1);
        repeat (10) send_word(OP_DEQ, 32'sd0);
        wait_drained();

        // Mixed traffic around small heap sizes.
        repeat (80) send_word(($urandom_range(1) == 0) ? OP_ENQ : OP_DEQ, pick_key());
        wait_drained();

        // Mostly enqueues until the heap is full, an enqueue while full, then mixed words: deep sifts both ways.
        while (sb.held < HEAP_CAP)
            send_word(($urandom_range(99) < 97) ? OP_ENQ : OP_DEQ, pick_key());
        send_word(OP_ENQ, pick_key());
        repeat (16) send_word(($urandom_range(99) < 65) ? OP_ENQ : OP_DEQ, pick_key());
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS binary_min_heap_queue");
        else
            $display("FAIL binary_min_heap_queue");
        $finish;
    end

endmodule
